[rtl/core/dtdn_pkg.sv]
// Shared types, constants and the month prefix table for the date to day number core.
package dtdn_pkg;

	localparam int DEF_MAX_YEAR = 9999;

	localparam logic [3:0] MONTH_LAST = 4'd11;
	localparam logic [3:0] MONTH_FEB  = 4'd1;

	// 41 * 400: keeps the biased year positive and leaves mod 16, 25 and 400 intact
	localparam logic [15:0] YEAR_BIAS = 16'd16400;
	localparam logic signed [10:0] CENT_BIAS = 11'sd164;
	localparam logic [15:0] CENT_ROUND = 16'd99;

	// floor(u / 25) = (u * RECIP_25) >> RECIP_SHIFT, exact for u below 32800
	localparam logic [12:0] RECIP_25 = 13'd5243;
	localparam int RECIP_SHIFT = 17;

	localparam logic signed [23:0] DAYS_PER_YEAR = 24'sd365;

	typedef struct packed {
		logic signed [14:0] year_in;
		logic [3:0]         month_in;
		logic [4:0]         day_in;
	} date_in_t;

	typedef struct packed {
		logic signed [22:0] day_number;
		logic               month_error;
	} date_out_t;

	typedef struct packed {
		logic signed [14:0] year;
		logic [15:0]        year_b;
		logic [3:0]         month;
		logic [4:0]         day;
		logic               err;
	} s1_t;

	typedef struct packed {
		logic signed [14:0] year;
		logic [15:0]        year_b;
		logic [9:0]         q100;
		logic [11:0]        q25;
		logic [8:0]         mstart;
		logic               after_feb;
		logic [4:0]         day;
		logic               err;
	} s2_t;

	typedef struct packed {
		logic signed [23:0] y365;
		logic signed [15:0] lcount;
		logic signed [10:0] offset;
		logic               err;
	} s3_t;

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/dtdn_front.sv]
// First stage: year saturation, year bias and month range check.
module dtdn_front import dtdn_pkg::*; #(
	parameter int MAX_YEAR = DEF_MAX_YEAR
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid,
	input  date_in_t item,
	output logic     valid_s1,
	output s1_t      item_s1
);

	localparam logic signed [16:0] MAX_Y = 17'(MAX_YEAR);
	localparam logic signed [16:0] MIN_Y = -MAX_Y;

	logic signed [16:0] year_x;
	logic signed [16:0] year_c;
	logic signed [14:0] year_sat;
	logic [15:0]        year_b;

	always_comb begin
		year_x = {{2{item.year_in[14]}}, item.year_in};
		if (year_x > MAX_Y) begin
			year_c = MAX_Y;
		end else if (year_x < MIN_Y) begin
			year_c = MIN_Y;
		end else begin
			year_c = year_x;
		end
		year_sat = year_c[14:0];
		year_b   = {year_sat[14], year_sat} + YEAR_BIAS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s1.year   <= year_sat;
		item_s1.year_b <= year_b;
		item_s1.month  <= item.month_in;
		item_s1.day    <= item.day_in;
		item_s1.err    <= (item.month_in > MONTH_LAST);
	end

endmodule

[rtl/core/dtdn_div.sv]
// Second stage: reciprocal divisions by 100 and 25 and the month prefix lookup.
module dtdn_div import dtdn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	input  s1_t  item,
	output logic valid_s2,
	output s2_t  item_s2
);

	logic [15:0] x100;
	logic [13:0] u100;
	logic [26:0] p100;
	logic [28:0] p25;

	always_comb begin
		// floor(x / 100) as floor(floor(x / 4) / 25)
		x100 = item.year_b + CENT_ROUND;
		u100 = x100[15:2];
		p100 = 27'(u100) * 27'(RECIP_25);
		p25  = 29'(item.year_b) * 29'(RECIP_25);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s2.year      <= item.year;
		item_s2.year_b    <= item.year_b;
		item_s2.q100      <= p100[26:RECIP_SHIFT];
		item_s2.q25       <= p25[28:RECIP_SHIFT];
		item_s2.mstart    <= month_start(item.month);
		item_s2.after_feb <= (item.month > MONTH_FEB);
		item_s2.day       <= item.day;
		item_s2.err       <= item.err;
	end

endmodule

[rtl/core/dtdn_count.sv]
// Third stage: leap-year count, leap test, whole-year days and in-year offset.
module dtdn_count import dtdn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	input  s2_t  item,
	output logic valid_s3,
	output s3_t  item_s3
);

	logic signed [10:0] c100;
	logic signed [10:0] c400;
	logic signed [15:0] y16;
	logic signed [15:0] c4;
	logic signed [15:0] lcount;
	logic [15:0]        r25;
	logic               leap;
	logic [10:0]        off_u;
	logic signed [23:0] yext;
	logic signed [23:0] y365;

	always_comb begin
		// ceil(y/100) from the biased quotient, then ceil(y/400) = ceil(ceil(y/100) / 4)
		c100   = $signed({1'b0, item.q100}) - CENT_BIAS;
		c400   = (c100 + 11'sd3) >>> 2;
		y16    = {item.year[14], item.year};
		c4     = (y16 + 16'sd3) >>> 2;
		lcount = c4 - {{5{c100[10]}}, c100} + {{5{c400[10]}}, c400};
		r25    = item.year_b - 16'({4'b0, item.q25} * 16'd25);
		leap   = (item.year[1:0] == 2'b00) && ((r25 != 16'd0) || (item.year[3:0] == 4'd0));
		off_u  = 11'(item.mstart) + 11'(leap && item.after_feb) + 11'(item.day) - 11'd1;
		yext   = {{9{item.year[14]}}, item.year};
		y365   = yext * DAYS_PER_YEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s3.y365   <= y365;
		item_s3.lcount <= lcount;
		item_s3.offset <= $signed(off_u);
		item_s3.err    <= item.err;
	end

endmodule

[rtl/core/date_to_day_number_core.sv]
// Top level of the proleptic Gregorian date to day number core.
// Converts one date per clock into the signed count of days since 1 January of year 0.
// The result appears with done high once the transfer has passed all four register stages,
// and done stays high for a single cycle only. Four
// register stages (saturate, divide, count, sum) each hold about one narrow multiply or
// one wide add, and that stage depth sets the clock, not any loop. busy is never raised,
// so start may be held high every cycle. Since there is no back-pressure, the receiver must
// capture every result in the cycle done is high. A month above 11 gives month_error set
// and day_number zero; years beyond MAX_YEAR in size are clamped before conversion.
module date_to_day_number_core import dtdn_pkg::*; #(
	parameter int MAX_YEAR = DEF_MAX_YEAR
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  date_in_t  date,
	output logic      done,
	output date_out_t result
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	s1_t  item_s1;
	s2_t  item_s2;
	s3_t  item_s3;

	logic signed [23:0] sum;

	// The pipeline never stalls, so a transfer is possible on every edge
	assign busy = 1'b0;

	dtdn_front #(
		.MAX_YEAR(MAX_YEAR)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (start && !busy),
		.item     (date),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dtdn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s1),
		.item     (item_s1),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2)
	);

	dtdn_count u_count (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s2),
		.item     (item_s2),
		.valid_s3 (valid_s3),
		.item_s3  (item_s3)
	);

	// Final stage: add whole-year days, leap days and the in-year offset
	always_comb begin
		sum = item_s3.y365
			+ {{8{item_s3.lcount[15]}}, item_s3.lcount}
			+ {{13{item_s3.offset[10]}}, item_s3.offset};
	end

	// Strobe the result for one cycle per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	// Drop the day count on a bad month; keep the low 23 bits otherwise
	always_ff @(posedge clk) begin
		result.day_number  <= item_s3.err ? 23'sd0 : sum[22:0];
		result.month_error <= item_s3.err;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("transfer did not produce a result after four cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##4 !done)
		else $error("result strobe without a matching transfer");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.month_error) |-> (result.day_number == 23'sd0))
		else $error("month error with non-zero day number");

	a_err_match: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 (result.month_error == $past(date.month_in > MONTH_LAST, 4)))
		else $error("month error flag does not match the transferred month");

endmodule
